// ===== rtl/ppc_pkg.sv =====
`timescale 1ns / 1ps

package ppc_pkg;

	localparam int unsigned PACKAGE_BYTES = 1024;
	localparam int unsigned HEADER_BYTES  = 16;
	localparam int unsigned MAX_PAYLOAD   = PACKAGE_BYTES - HEADER_BYTES;
	localparam int unsigned CNT_W         = $clog2(PACKAGE_BYTES) + 1;
	localparam int unsigned QUEUE_DEPTH   = 4;
	localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W        = QPTR_W + 1;

	localparam logic [31:0] PKG_MAGIC  = 32'h3176_4750;
	localparam logic [31:0] CRC_POLY   = 32'h0000_1021;
	localparam logic [31:0] TYPE_RESET = 32'h0000_0003;
	localparam logic [9:0]  LEN_RESET  = 10'd1008;

	localparam logic [1:0] REG_EXPECTED_TYPE = 2'd0;
	localparam logic [1:0] REG_MAX_LENGTH    = 2'd1;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_DONE    = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		V_OK     = 3'd0,
		V_MAGIC  = 3'd1,
		V_TYPE   = 3'd2,
		V_LENGTH = 3'd3,
		V_CRC    = 3'd4
	} verdict_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] value;
		logic [2:0] verdict;
		logic       final_item;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

	function automatic logic [31:0] crc_feed(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {16'd0, b, 8'd0};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = (c << 1) ^ CRC_POLY;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/provisioning_package_checker.sv =====
`timescale 1ns / 1ps
// The results of an accepted item are registered in the result queue and read out from its head.
// Throughput: one item per cycle while in_ready is high; a four-entry result queue absorbs the extra verdict item.
// The input stalls only while the result queue holds more than two items.
// Reset (arst_n low) clears the checker to idle, empties the queue and restores the registers.

module provisioning_package_checker import ppc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        first_byte,
	input  logic [7:0]  package_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        item_kind,
	output logic [7:0]  payload_value,
	output logic [2:0]  verdict,
	output logic        final_item,
	input  logic        cfg_write_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	push_t              push;
	result_t            head;
	logic [QCNT_W-1:0]  level;
	logic               accept;
	logic               pop;

	assign in_ready  = (level <= QCNT_W'(QUEUE_DEPTH - 2));
	assign accept    = in_valid && in_ready;
	assign out_valid = (level != '0);
	assign pop       = out_valid && out_ready;

	assign item_kind     = head.kind;
	assign payload_value = head.value;
	assign verdict       = head.verdict;
	assign final_item    = head.final_item;

	ppc_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.first_byte   (first_byte),
		.package_byte (package_byte),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push)
	);

	ppc_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.level  (level)
	);

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level <= QCNT_W'(QUEUE_DEPTH))
		else $error("result queue overflow");

	a_no_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |-> push.count == 2'd0)
		else $error("result produced without an accepted item");

	a_final_is_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> final_item == item_kind)
		else $error("final flag does not match item kind");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind |-> payload_value == 8'd0)
		else $error("verdict item carries payload data");

endmodule

// ===== rtl/ppc_core.sv =====
`timescale 1ns / 1ps

module ppc_core import ppc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic        first_byte,
	input  logic [7:0]  package_byte,
	input  logic        cfg_write_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output push_t       push
);

	phase_t            phase_q, phase_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [31:0]       word_q, word_d;
	logic [9:0]        len_q, len_d;
	logic [31:0]       ecrc_q, ecrc_d;
	logic [31:0]       crc_q, crc_d;
	logic [31:0]       type_q;
	logic [9:0]        maxlen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_q   <= TYPE_RESET;
			maxlen_q <= LEN_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_EXPECTED_TYPE: type_q   <= cfg_data;
				REG_MAX_LENGTH:    maxlen_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			word_q  <= '0;
			len_q   <= '0;
			ecrc_q  <= '0;
			crc_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			word_q  <= word_d;
			len_q   <= len_d;
			ecrc_q  <= ecrc_d;
			crc_q   <= crc_d;
		end
	end

	always_comb begin
		result_t vitem;
		phase_d = phase_q;
		cnt_d   = cnt_q;
		word_d  = word_q;
		len_d   = len_q;
		ecrc_d  = ecrc_q;
		crc_d   = crc_q;
		push    = '0;
		vitem   = '0;
		vitem.kind       = 1'b1;
		vitem.final_item = 1'b1;

		if (first_byte) begin
			phase_d = PH_HEADER;
			cnt_d   = '0;
			word_d  = '0;
			len_d   = '0;
			ecrc_d  = '0;
			crc_d   = '0;
		end

		case (phase_d)
			PH_HEADER: begin
				word_d = {package_byte, word_d[31:8]};
				cnt_d  = cnt_d + 1'b1;
				if (cnt_d[1:0] == 2'd0) begin
					if (cnt_d == CNT_W'(4)) begin
						if (word_d != PKG_MAGIC) begin
							vitem.verdict = V_MAGIC;
							push.count    = 2'd1;
							push.first    = vitem;
							phase_d       = PH_DONE;
						end
					end else if (cnt_d == CNT_W'(8)) begin
						if (word_d != type_q) begin
							vitem.verdict = V_TYPE;
							push.count    = 2'd1;
							push.first    = vitem;
							phase_d       = PH_DONE;
						end
					end else if (cnt_d == CNT_W'(12)) begin
						if (word_d > {22'd0, maxlen_q} || word_d > 32'(MAX_PAYLOAD)) begin
							vitem.verdict = V_LENGTH;
							push.count    = 2'd1;
							push.first    = vitem;
							phase_d       = PH_DONE;
						end else begin
							len_d = word_d[9:0];
						end
					end else if (cnt_d >= CNT_W'(HEADER_BYTES)) begin
						ecrc_d  = word_d;
						cnt_d   = '0;
						crc_d   = '0;
						phase_d = PH_PAYLOAD;
						if (len_d == 10'd0) begin
							vitem.verdict = (word_d == 32'd0) ? V_OK : V_CRC;
							push.count    = 2'd1;
							push.first    = vitem;
							phase_d       = PH_DONE;
						end
					end
				end
			end
			PH_PAYLOAD: begin
				push.count       = 2'd1;
				push.first.value = package_byte;
				crc_d = crc_feed(crc_d, package_byte);
				cnt_d = cnt_d + 1'b1;
				if (cnt_d >= {{(CNT_W-10){1'b0}}, len_d}) begin
					vitem.verdict = (crc_d == ecrc_d) ? V_OK : V_CRC;
					push.count    = 2'd2;
					push.second   = vitem;
					phase_d       = PH_DONE;
				end
			end
			default: ;
		endcase

		if (!accept) begin
			push.count = 2'd0;
		end
	end

endmodule

// ===== rtl/ppc_outq.sv =====
`timescale 1ns / 1ps

module ppc_outq import ppc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  push_t             push,
	input  logic              pop,
	output result_t           head,
	output logic [QCNT_W-1:0] level
);

	result_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  rd_q;
	logic [QPTR_W-1:0]  wr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic [QPTR_W-1:0]  wr_next;

	assign wr_next = wr_q + 1'b1;
	assign head    = mem_q[rd_q];
	assign level   = cnt_q;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_next] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(push.count);
			rd_q  <= rd_q + QPTR_W'(pop);
			cnt_q <= cnt_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

endmodule

// ===== bench/provisioning_package_checker_tb.sv =====
`timescale 1ns / 1ps

module provisioning_package_checker_tb;
	import ppc_pkg::*;

	localparam int CYCLE_LIMIT    = 1_000_000;
	localparam int RANDOM_ITEMS   = 800;
	localparam int CALM_FROM      = 700;
	localparam int SETTLE_CYCLES  = 4;
	localparam int NUM_DIR_ROWS   = 22;

	localparam logic [1:0] REG_UNMAPPED_LO = 2'd2;
	localparam logic [1:0] REG_UNMAPPED_HI = 2'd3;

	typedef struct packed {
		logic        set_cfg;
		logic [31:0] cfg_type;
		logic [9:0]  cfg_limit;
		int          lead;
		logic [31:0] magic;
		logic [31:0] ptype;
		logic [31:0] len_word;
		int          pay_n;
		logic        bad_crc;
		int          cut;
		int          trail;
		logic        pinned;
		verdict_t    verd;
	} dir_row_t;

	// set, type, limit, lead, magic, type, length, payload, bad crc, cut, trail, pinned, verdict
	localparam dir_row_t DIR_ROWS [NUM_DIR_ROWS] = '{
	'{1'b0, 32'h0, 10'd0, 3, PKG_MAGIC, TYPE_RESET, 32'd0, 0, 1'b0, -1, 0, 1'b1, V_OK},
	'{1'b0, 32'h0, 10'd0, 0, 32'h0, TYPE_RESET, 32'd4, 4, 1'b0, -1, 0, 1'b1, V_MAGIC},
	'{1'b0, 32'h0, 10'd0, 0, 32'hFFFF_FFFF, TYPE_RESET, 32'd0, 0, 1'b0, -1, 0, 1'b1, V_MAGIC},
	'{1'b0, 32'h0, 10'd0, 0, 32'hB176_4751, TYPE_RESET, 32'd1, 1, 1'b0, -1, 0, 1'b1, V_MAGIC},
	'{1'b0, 32'h0, 10'd0, 0, PKG_MAGIC, 32'h1, 32'd2, 2, 1'b0, -1, 0, 1'b1, V_TYPE},
	'{1'b0, 32'h0, 10'd0, 0, PKG_MAGIC, 32'hFFFF_FFFF, 32'd0, 0, 1'b0, -1, 0, 1'b1, V_TYPE},
	'{1'b0, 32'h0, 10'd0, 0, PKG_MAGIC, TYPE_RESET, 32'd1009, 3, 1'b0, -1, 0, 1'b1, V_LENGTH},
	'{1'b0, 32'h0, 10'd0, 0, PKG_MAGIC, TYPE_RESET, 32'hFFFF_FFFF, 0, 1'b0, -1, 0, 1'b1, V_LENGTH},
	'{1'b0, 32'h0, 10'd0, 0, PKG_MAGIC, TYPE_RESET, 32'd0, 0, 1'b1, -1, 0, 1'b1, V_CRC},
	'{1'b0, 32'h0, 10'd0, 0, PKG_MAGIC, TYPE_RESET, 32'd1, 1, 1'b0, -1, 0, 1'b0, V_OK},
	'{1'b0, 32'h0, 10'd0, 0, PKG_MAGIC, TYPE_RESET, 32'd3, 3, 1'b1, -1, 0, 1'b0, V_OK},
	'{1'b0, 32'h0, 10'd0, 0, PKG_MAGIC, TYPE_RESET, 32'd5, 5, 1'b0, 10, 0, 1'b0, V_OK},
	'{1'b0, 32'h0, 10'd0, 0, PKG_MAGIC, TYPE_RESET, 32'd6, 6, 1'b0, 19, 0, 1'b0, V_OK},
	'{1'b0, 32'h0, 10'd0, 0, PKG_MAGIC, TYPE_RESET, 32'd1008, 1008, 1'b0, -1, 0, 1'b0, V_OK},
	'{1'b0, 32'h0, 10'd0, 0, PKG_MAGIC, TYPE_RESET, 32'd2, 2, 1'b0, -1, 3, 1'b0, V_OK},
	'{1'b1, 32'h0, 10'd1023, 0, PKG_MAGIC, 32'h0, 32'd1012, 2, 1'b0, -1, 0, 1'b1, V_LENGTH},
	'{1'b0, 32'h0, 10'd0, 0, PKG_MAGIC, 32'h0, 32'd4, 4, 1'b0, -1, 0, 1'b0, V_OK},
	'{1'b1, 32'hFFFF_FFFF, 10'd0, 0, PKG_MAGIC, 32'hFFFF_FFFF, 32'd1, 1, 1'b0, -1, 0, 1'b1,
		V_LENGTH},
	'{1'b0, 32'h0, 10'd0, 0, PKG_MAGIC, 32'hFFFF_FFFF, 32'd0, 0, 1'b0, -1, 0, 1'b1, V_OK},
	'{1'b1, 32'h1, 10'd7, 0, PKG_MAGIC, 32'h1, 32'd7, 7, 1'b0, -1, 0, 1'b0, V_OK},
	'{1'b0, 32'h0, 10'd0, 0, PKG_MAGIC, 32'h1, 32'd8, 2, 1'b0, -1, 0, 1'b1, V_LENGTH},
	'{1'b1, TYPE_RESET, LEN_RESET, 0, PKG_MAGIC, TYPE_RESET, 32'd12, 12, 1'b0, -1, 2, 1'b0, V_OK}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        first_byte = 1'b0;
	logic [7:0]  package_byte = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        item_kind;
	logic [7:0]  payload_value;
	logic [2:0]  verdict;
	logic        final_item;
	logic        cfg_write_en = 1'b0;
	logic [1:0]  cfg_index = 2'd0;
	logic [31:0] cfg_data = 32'd0;

	result_t     payload_and_verdict_q [$];
	result_t     want;
	int          fail_count = 0;
	int          live_items = 0;
	int          cycle_count = 0;
	int          out_stall_left = 0;
	bit          sender_idle_on = 1'b0;
	bit          receiver_idle_on = 1'b0;
	bit          calm = 1'b0;
	bit          verdict_pinned = 1'b0;
	verdict_t    pinned_verdict = V_OK;

	phase_t      model_phase = PH_IDLE;
	logic [10:0] hdr_count = '0;
	logic [31:0] word_acc = '0;
	logic [9:0]  pay_len = '0;
	logic [31:0] crc_want = '0;
	logic [31:0] crc_run = '0;
	logic [31:0] type_reg = TYPE_RESET;
	logic [9:0]  len_limit = LEN_RESET;

	provisioning_package_checker dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.first_byte(first_byte),
		.package_byte(package_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.item_kind(item_kind),
		.payload_value(payload_value),
		.verdict(verdict),
		.final_item(final_item),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] crc_shift_byte(input logic [31:0] acc, input logic [7:0] data);
		logic [31:0] r;
		r = acc;
		r[15:8] = r[15:8] ^ data;
		repeat (8) r = {r[30:0], 1'b0} ^ (r[15] ? CRC_POLY : 32'd0);
		return r;
	endfunction

	function automatic void post_payload(input logic [7:0] b);
		result_t r;
		r.kind = 1'b0;
		r.value = b;
		r.verdict = V_OK;
		r.final_item = 1'b0;
		payload_and_verdict_q.push_back(r);
	endfunction

	function automatic void post_verdict(input verdict_t v);
		result_t r;
		r.kind = 1'b1;
		r.value = 8'd0;
		r.verdict = verdict_pinned ? pinned_verdict : v;
		r.final_item = 1'b1;
		payload_and_verdict_q.push_back(r);
		model_phase = PH_DONE;
	endfunction

	function automatic void track_package_byte(input logic fb, input logic [7:0] b);
		if (fb || model_phase == PH_HEADER || model_phase == PH_PAYLOAD) begin
			live_items++;
		end
		if (fb) begin
			model_phase = PH_HEADER;
			hdr_count = '0;
			word_acc = '0;
			pay_len = '0;
			crc_want = '0;
			crc_run = '0;
		end
		if (model_phase == PH_HEADER) begin
			word_acc = {b, word_acc[31:8]};
			hdr_count = hdr_count + 11'd1;
			if (hdr_count[1:0] == 2'd0) begin
				if (hdr_count == 11'd4) begin
					if (word_acc != PKG_MAGIC) begin
						post_verdict(V_MAGIC);
					end
				end else if (hdr_count == 11'd8) begin
					if (word_acc != type_reg) begin
						post_verdict(V_TYPE);
					end
				end else if (hdr_count == 11'd12) begin
					if (word_acc > {22'd0, len_limit} || word_acc > 32'(MAX_PAYLOAD)) begin
						post_verdict(V_LENGTH);
					end else begin
						pay_len = word_acc[9:0];
					end
				end else if (hdr_count >= 11'(HEADER_BYTES)) begin
					crc_want = word_acc;
					hdr_count = '0;
					crc_run = '0;
					model_phase = PH_PAYLOAD;
					if (pay_len == 10'd0) begin
						post_verdict(crc_run == crc_want ? V_OK : V_CRC);
					end
				end
			end
		end else if (model_phase == PH_PAYLOAD) begin
			post_payload(b);
			crc_run = crc_shift_byte(crc_run, b);
			hdr_count = hdr_count + 11'd1;
			if (hdr_count >= {1'b0, pay_len}) begin
				post_verdict(crc_run == crc_want ? V_OK : V_CRC);
			end
		end
	endfunction

	function automatic void check_field(input string name, input logic [7:0] exp,
		input logic [7:0] act);
		if (act !== exp) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, exp, act);
			fail_count++;
		end
	endfunction

	task automatic send_item(input logic fb, input logic [7:0] b);
		int gap;
		if (sender_idle_on && !calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 9);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		first_byte <= fb;
		package_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		track_package_byte(fb, b);
	endtask

	task automatic send_package(input logic [31:0] magic, input logic [31:0] ptype,
		input logic [31:0] len_word, input int pay_n, input logic bad_crc, input int cut,
		input int trail);
		logic [7:0]  stream [$];
		logic [7:0]  body [$];
		logic [31:0] crc;
		logic [31:0] words [4];
		int          total;
		int          i;
		int          k;
		crc = '0;
		for (i = 0; i < pay_n; i++) begin
			body.push_back(8'($urandom_range(0, 255)));
			crc = crc_shift_byte(crc, body[i]);
		end
		if (bad_crc) begin
			crc = crc ^ ($urandom() | 32'h1);
		end
		words = '{magic, ptype, len_word, crc};
		for (i = 0; i < 4; i++) begin
			for (k = 0; k < 4; k++) begin
				stream.push_back(words[i][8 * k +: 8]);
			end
		end
		for (i = 0; i < pay_n; i++) begin
			stream.push_back(body[i]);
		end
		total = (cut >= 0 && cut < stream.size()) ? cut : stream.size();
		for (i = 0; i < total; i++) begin
			send_item(i == 0, stream[i]);
		end
		repeat (trail) send_item(1'b0, 8'($urandom_range(0, 255)));
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (payload_and_verdict_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_settings(input logic [31:0] t, input logic [9:0] lim);
		logic [31:0] noise;
		noise = $urandom();
		cfg_write_en <= 1'b1;
		cfg_index <= REG_EXPECTED_TYPE;
		cfg_data <= t;
		@(posedge clk);
		type_reg = t;
		cfg_index <= REG_MAX_LENGTH;
		cfg_data <= {noise[31:10], lim};
		@(posedge clk);
		len_limit = lim;
		cfg_index <= $urandom_range(0, 1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO;
		cfg_data <= $urandom();
		@(posedge clk);
		cfg_write_en <= 1'b0;
	endtask

	task automatic send_random_package();
		int          cap;
		int          len;
		int          pay;
		int          cut;
		int          trail;
		int          roll;
		logic        bad;
		logic [31:0] magic;
		logic [31:0] ptype;
		logic [31:0] len_word;
		cap = ({22'd0, len_limit} < 32'(MAX_PAYLOAD)) ? int'(len_limit) : int'(MAX_PAYLOAD);
		len = ($urandom_range(0, 49) == 0) ? cap : $urandom_range(0, (cap < 24) ? cap : 24);
		magic = PKG_MAGIC;
		ptype = type_reg;
		len_word = len;
		pay = len;
		bad = 1'b0;
		cut = -1;
		trail = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0;
		roll = $urandom_range(0, 99);
		if (roll < 12) begin
			bad = 1'b1;
		end else if (roll < 17) begin
			magic = $urandom_range(0, 1) ? $urandom() : PKG_MAGIC ^ (32'h1 << $urandom_range(0, 31));
		end else if (roll < 22) begin
			ptype = type_reg ^ (32'h1 << $urandom_range(0, 31));
		end else if (roll < 28) begin
			len_word = $urandom_range(0, 1) ? $urandom() : cap + $urandom_range(1, 16);
			pay = $urandom_range(0, 4);
		end else if (roll < 34) begin
			cut = $urandom_range(1, 15 + len);
		end
		sender_idle_on = $urandom_range(0, 3) != 0;
		receiver_idle_on = $urandom_range(0, 3) != 0;
		send_package(magic, ptype, len_word, pay, bad, cut, trail);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (payload_and_verdict_q.size() == 0) begin
				$display("%0t: unexpected item kind=%0d value=%0h verdict=%0d final=%0d",
					$time, item_kind, payload_value, verdict, final_item);
				fail_count++;
			end else begin
				want = payload_and_verdict_q.pop_front();
				check_field("item_kind", 8'(want.kind), 8'(item_kind));
				check_field("payload_value", want.value, payload_value);
				check_field("verdict", 8'(want.verdict), 8'(verdict));
				check_field("final_item", 8'(want.final_item), 8'(final_item));
			end
		end
		if (calm) begin
			out_ready <= 1'b1;
		end else if (out_stall_left > 0) begin
			out_stall_left--;
			out_ready <= 1'b0;
		end else if (receiver_idle_on && $urandom_range(0, 5) == 0) begin
			out_stall_left = $urandom_range(0, 8);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int       live_mark;
		int       left_in_phase;
		dir_row_t row;
		logic [31:0] t;
		logic [9:0]  lim;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIR_ROWS; i++) begin
			row = DIR_ROWS[i];
			if (row.set_cfg) begin
				settle();
				apply_settings(row.cfg_type, row.cfg_limit);
			end
			sender_idle_on = $urandom_range(0, 1) != 0;
			receiver_idle_on = $urandom_range(0, 1) != 0;
			repeat (row.lead) send_item(1'b0, 8'($urandom_range(0, 255)));
			verdict_pinned = row.pinned;
			pinned_verdict = row.verd;
			send_package(row.magic, row.ptype, row.len_word, row.pay_n, row.bad_crc, row.cut,
				row.trail);
			verdict_pinned = 1'b0;
		end

		live_mark = live_items;
		left_in_phase = 0;
		while (live_items - live_mark < RANDOM_ITEMS) begin
			if (left_in_phase == 0) begin
				settle();
				case ($urandom_range(0, 3))
					0: t = TYPE_RESET;
					1: t = 32'h1;
					default: t = $urandom();
				endcase
				case ($urandom_range(0, 4))
					0: lim = LEN_RESET;
					1: lim = 10'd1023;
					2: lim = 10'd0;
					default: lim = 10'($urandom_range(1, 40));
				endcase
				apply_settings(t, lim);
				left_in_phase = $urandom_range(4, 10);
			end
			calm = (live_items - live_mark) >= CALM_FROM;
			send_random_package();
			left_in_phase--;
		end

		in_valid <= 1'b0;
		while (payload_and_verdict_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
